// File: src/rpn_pkg.sv
`default_nettype none

package rpn_pkg;

  // default sizes
  localparam int unsigned STACK_DEPTH_DEF = 16;
  localparam int unsigned VALUE_WIDTH_DEF = 32;
  localparam int unsigned VAR_COUNT_DEF   = 16;

  // fixed field widths
  localparam int unsigned FIELD_W   = 32;
  localparam int unsigned ACT_W     = 4;
  localparam int unsigned VIDX_W    = 4;
  localparam int unsigned ERR_W     = 3;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned SLOT_CNT  = 16;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH_CONST = 4'd0,
    ACT_PUSH_VAR   = 4'd1,
    ACT_ADD        = 4'd2,
    ACT_SUB        = 4'd3,
    ACT_MUL        = 4'd4,
    ACT_DIV        = 4'd5,
    ACT_MOD        = 4'd6,
    ACT_WRITE_VAR  = 4'd7,
    ACT_ABORT      = 4'd8
  } action_e;

  localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_EACH_RUN = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_RES    = 4'd1;

  localparam logic [ERR_W-1:0] ERR_OVF = 3'b001;
  localparam logic [ERR_W-1:0] ERR_UNF = 3'b010;
  localparam logic [ERR_W-1:0] ERR_DZ  = 3'b100;

  typedef enum logic [1:0] {
    WB_ALU  = 2'd0,
    WB_ZERO = 2'd1,
    WB_MD   = 2'd2
  } wb_sel_e;

  typedef enum logic [1:0] {
    MD_MUL = 2'd0,
    MD_DIV = 2'd1,
    MD_MOD = 2'd2
  } md_op_e;

  typedef struct packed {
    logic [ACT_W-1:0]          action;
    logic signed [FIELD_W-1:0] operand_value;
    logic [VIDX_W-1:0]         var_index;
    logic                      last;
  } in_item_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] result_value;
    logic [ERR_W-1:0]          error_flags;
    logic                      was_missing;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [FIELD_W-1:0]   data;
  } cfg_item_t;

  // controller -> datapath
  typedef struct packed {
    logic             load;
    logic             var_wr;
    logic             push;
    logic             wb;
    wb_sel_e          wb_sel;
    logic             md_start;
    logic [ERR_W-1:0] set_err;
    logic             set_missing;
    logic             take_top;
    logic             emit;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic             last;
    logic             cnt_zero;
    logic             cnt_lt2;
    logic             top_zero;
    logic             md_done;
    logic             out_free;
  } status_t;

  typedef logic [SLOT_CNT-1:0][7:0] slot_map_t;

  // variable index folded onto the table size, by repeated subtraction
  function automatic slot_map_t slot_map(input int unsigned n);
    slot_map_t   m;
    int unsigned r;
    for (int i = 0; i < SLOT_CNT; i++) begin
      r = i;
      for (int j = 0; j < SLOT_CNT; j++) begin
        if (r >= n) r = r - n;
      end
      m[i] = 8'(r);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// File: src/rpn_stream_if.sv
`default_nettype none

interface rpn_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: src/rpn_muldiv.sv
`default_nettype none

module rpn_muldiv #(
  parameter int unsigned VALUE_WIDTH = rpn_pkg::VALUE_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  rpn_pkg::md_op_e        op_i,
  input  logic [VALUE_WIDTH-1:0] a_i,
  input  logic [VALUE_WIDTH-1:0] b_i,
  output logic                   done_o,
  output logic [VALUE_WIDTH-1:0] result_o
);
  import rpn_pkg::*;

  localparam int unsigned W   = VALUE_WIDTH;
  localparam int unsigned CW  = $clog2(W);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [W-1:0]  a_q, a_d;
  logic [W-1:0]  b_q, b_d;
  logic [W-1:0]  acc_q, acc_d;
  logic          neg_q, neg_d;
  md_op_e        op_q, op_d;

  logic [W-1:0]  mag_a, mag_b;
  logic [W:0]    trial;
  logic [W:0]    trial_sub;

  assign mag_a     = a_i[W-1] ? (W'(0) - a_i) : a_i;
  assign mag_b     = b_i[W-1] ? (W'(0) - b_i) : b_i;
  assign trial     = {acc_q, a_q[W-1]};
  assign trial_sub = trial - {1'b0, b_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    neg_d  = neg_q;
    op_d   = op_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      op_d   = op_i;
      acc_d  = '0;
      if (op_i == MD_MUL) begin
        a_d   = a_i;
        b_d   = b_i;
        neg_d = 1'b0;
      end else begin
        a_d   = mag_a;
        b_d   = mag_b;
        // remainder follows the dividend, quotient the sign product
        neg_d = (op_i == MD_MOD) ? a_i[W-1] : (a_i[W-1] ^ b_i[W-1]);
      end
    end else if (busy_q) begin
      if (op_q == MD_MUL) begin
        if (b_q[0]) acc_d = acc_q + a_q;
        a_d = {a_q[W-2:0], 1'b0};
        b_d = {1'b0, b_q[W-1:1]};
      end else begin
        // restoring division, one quotient bit per cycle
        if (!trial_sub[W]) begin
          acc_d = trial_sub[W-1:0];
          a_d   = {a_q[W-2:0], 1'b1};
        end else begin
          acc_d = trial[W-1:0];
          a_d   = {a_q[W-2:0], 1'b0};
        end
      end
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == CW'(W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
    neg_q <= neg_d;
    op_q  <= op_d;
  end

  always_comb begin
    unique case (op_q)
      MD_MUL:  result_o = acc_q;
      MD_DIV:  result_o = neg_q ? (W'(0) - a_q) : a_q;
      MD_MOD:  result_o = neg_q ? (W'(0) - acc_q) : acc_q;
      default: result_o = acc_q;
    endcase
  end

  assign done_o = done_q;

endmodule

`default_nettype wire

// File: src/rpn_datapath.sv
`default_nettype none

module rpn_datapath #(
  parameter int unsigned STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF,
  parameter int unsigned VALUE_WIDTH = rpn_pkg::VALUE_WIDTH_DEF,
  parameter int unsigned VAR_COUNT   = rpn_pkg::VAR_COUNT_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rpn_pkg::in_item_t   in_item_i,
  input  logic                cfg_we_i,
  input  rpn_pkg::cfg_item_t  cfg_item_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output rpn_pkg::out_item_t  out_item_o,
  input  rpn_pkg::cmd_t       cmd_i,
  output rpn_pkg::status_t    status_o
);
  import rpn_pkg::*;

  localparam int unsigned W     = VALUE_WIDTH;
  localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW    = $clog2(STACK_DEPTH);
  localparam int unsigned VAW   = (VAR_COUNT > 1) ? $clog2(VAR_COUNT) : 1;
  localparam slot_map_t   SLOT_MAP = slot_map(VAR_COUNT);

  // memories
  logic [W-1:0] stack_mem [STACK_DEPTH];
  logic [W-1:0] var_mem   [VAR_COUNT];

  // config
  logic                      clear_q;
  logic signed [FIELD_W-1:0] missing_q;

  // stack control
  logic [CNT_W-1:0] count_q, count_d;
  logic [ERR_W-1:0] err_q, err_d;
  logic             in_run_q, in_run_d;

  // latched item
  logic [ACT_W-1:0] act_q;
  logic [W-1:0]     opnd_q;
  logic [VAW-1:0]   slot_q;
  logic             last_q;

  // memory read data
  logic [W-1:0] rd_top_q, rd_nxt_q, var_rd_q;

  // result and output
  logic [W-1:0] res_q;
  logic         miss_q;
  logic         out_valid_q, out_valid_d;
  out_item_t    out_item_q;

  logic [CNT_W-1:0] cnt_m1, cnt_m2;
  logic [AW-1:0]    addr_top, addr_nxt;
  logic [VAW-1:0]   in_slot;
  logic             full;
  logic [W-1:0]     push_val, alu_val, wb_val, md_res, missing_w;
  logic             st_we;
  logic [AW-1:0]    st_wa;
  logic [W-1:0]     st_wd;
  logic             md_done;
  md_op_e           md_op;

  assign cnt_m1    = count_q - CNT_W'(1);
  assign cnt_m2    = count_q - CNT_W'(2);
  assign addr_top  = cnt_m1[AW-1:0];
  assign addr_nxt  = cnt_m2[AW-1:0];
  assign in_slot   = SLOT_MAP[in_item_i.var_index][VAW-1:0];
  assign full      = (count_q >= CNT_W'(STACK_DEPTH));
  assign missing_w = W'(missing_q);

  assign push_val = (act_q == ACT_PUSH_VAR) ? var_rd_q : opnd_q;
  assign alu_val  = (act_q == ACT_SUB) ? (rd_nxt_q - rd_top_q) : (rd_nxt_q + rd_top_q);

  always_comb begin
    unique case (cmd_i.wb_sel)
      WB_ALU:  wb_val = alu_val;
      WB_ZERO: wb_val = '0;
      WB_MD:   wb_val = md_res;
      default: wb_val = '0;
    endcase
  end

  always_comb begin
    unique case (act_q)
      ACT_DIV: md_op = MD_DIV;
      ACT_MOD: md_op = MD_MOD;
      default: md_op = MD_MUL;
    endcase
  end

  rpn_muldiv #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_muldiv (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cmd_i.md_start),
    .op_i     (md_op),
    .a_i      (rd_nxt_q),
    .b_i      (rd_top_q),
    .done_o   (md_done),
    .result_o (md_res)
  );

  // single stack write port: push at the top, or binary result one below
  assign st_we = (cmd_i.push && !full) || cmd_i.wb;
  assign st_wa = cmd_i.push ? count_q[AW-1:0] : addr_nxt;
  assign st_wd = cmd_i.push ? push_val : wb_val;

  always_ff @(posedge clk_i) begin
    if (st_we) stack_mem[st_wa] <= st_wd;
    rd_top_q <= stack_mem[addr_top];
    rd_nxt_q <= stack_mem[addr_nxt];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.var_wr) var_mem[slot_q] <= opnd_q;
    var_rd_q <= var_mem[in_slot];
  end

  always_comb begin
    count_d  = count_q;
    err_d    = err_q;
    in_run_d = in_run_q;
    if (cmd_i.load && (in_item_i.action != ACT_WRITE_VAR)) begin
      if (!in_run_q && clear_q) begin
        count_d = '0;
        err_d   = '0;
      end
      in_run_d = 1'b1;
    end
    if (cmd_i.push) begin
      if (full) err_d = err_q | ERR_OVF;
      else      count_d = count_q + CNT_W'(1);
    end
    if (cmd_i.wb || cmd_i.take_top) count_d = cnt_m1;
    err_d = err_d | cmd_i.set_err;
    if (cmd_i.emit) in_run_d = 1'b0;
  end

  assign out_valid_d = cmd_i.emit ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      err_q       <= '0;
      in_run_q    <= 1'b0;
      out_valid_q <= 1'b0;
      clear_q     <= 1'b1;
      missing_q   <= '0;
    end else begin
      count_q     <= count_d;
      err_q       <= err_d;
      in_run_q    <= in_run_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_item_i.index)
          CFG_CLEAR_EACH_RUN: clear_q   <= cfg_item_i.data[0];
          CFG_DEFAULT_RES:    missing_q <= cfg_item_i.data;
          default:            ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q  <= in_item_i.action;
      opnd_q <= W'(in_item_i.operand_value);
      slot_q <= in_slot;
      last_q <= in_item_i.last;
    end
    if (cmd_i.set_missing) begin
      res_q  <= missing_w;
      miss_q <= 1'b1;
    end else if (cmd_i.take_top) begin
      res_q  <= rd_top_q;
      miss_q <= 1'b0;
    end
    if (cmd_i.emit) begin
      out_item_q.result_value <= FIELD_W'(signed'(res_q));
      out_item_q.error_flags  <= err_q;
      out_item_q.was_missing  <= miss_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  assign status_o.act      = act_q;
  assign status_o.last     = last_q;
  assign status_o.cnt_zero = (count_q == '0);
  assign status_o.cnt_lt2  = (count_q < CNT_W'(2));
  assign status_o.top_zero = (rd_top_q == '0);
  assign status_o.md_done  = md_done;
  assign status_o.out_free = !out_valid_q || out_ready_i;

endmodule

`default_nettype wire

// File: src/rpn_ctrl.sv
`default_nettype none

module rpn_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  rpn_pkg::status_t status_i,
  output rpn_pkg::cmd_t    cmd_o
);
  import rpn_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_WAIT = 3'd2;
  localparam logic [2:0] S_POP  = 3'd3;
  localparam logic [2:0] S_TAKE = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  logic [2:0] state_q, state_d;
  logic [2:0] fin_state;

  assign fin_state  = status_i.last ? S_POP : S_IDLE;
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o        = '0;
    cmd_o.wb_sel = WB_ALU;
    state_d      = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = fin_state;
        unique case (status_i.act)
          ACT_WRITE_VAR: begin
            cmd_o.var_wr = 1'b1;
            state_d      = S_IDLE;
          end
          ACT_ABORT: begin
            cmd_o.set_missing = 1'b1;
            state_d           = S_EMIT;
          end
          ACT_PUSH_CONST, ACT_PUSH_VAR: begin
            cmd_o.push = 1'b1;
          end
          ACT_ADD, ACT_SUB: begin
            if (status_i.cnt_lt2) cmd_o.set_err = ERR_UNF;
            else                  cmd_o.wb      = 1'b1;
          end
          ACT_MUL: begin
            if (status_i.cnt_lt2) begin
              cmd_o.set_err = ERR_UNF;
            end else begin
              cmd_o.md_start = 1'b1;
              state_d        = S_WAIT;
            end
          end
          ACT_DIV, ACT_MOD: begin
            priority if (status_i.cnt_lt2) begin
              cmd_o.set_err = ERR_UNF;
            end else if (status_i.top_zero) begin
              cmd_o.set_err = ERR_DZ;
              cmd_o.wb      = 1'b1;
              cmd_o.wb_sel  = WB_ZERO;
            end else begin
              cmd_o.md_start = 1'b1;
              state_d        = S_WAIT;
            end
          end
          default: ;
        endcase
      end
      S_WAIT: begin
        if (status_i.md_done) begin
          cmd_o.wb     = 1'b1;
          cmd_o.wb_sel = WB_MD;
          state_d      = fin_state;
        end
      end
      S_POP: begin
        if (status_i.cnt_zero) begin
          cmd_o.set_err     = ERR_UNF;
          cmd_o.set_missing = 1'b1;
          state_d           = S_EMIT;
        end else begin
          state_d = S_TAKE;
        end
      end
      S_TAKE: begin
        cmd_o.take_top = 1'b1;
        state_d        = S_EMIT;
      end
      S_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// File: src/rpn_stack_evaluator_core.sv
// postfix expression evaluator on a bounded signed stack
// channels: in_i takes one expression entry per item (action, operand_value,
//   var_index, last); out_o gives one result item per finished expression;
//   cfg_i writes clear_each_run (index 0) or the empty-result value (index 1),
//   always ready
// steps per item: accept, then execute; mul, div and mod then wait on the
//   bit-serial multiply/divide unit, which retires one bit per cycle, unless
//   there are too few values or (div and mod) a zero divisor; an item marked
//   last, other than a variable write, goes on to stack read, pop and output
//   load, or to output load alone on an empty stack; an abort goes to output load
// the stack and variable table are single-write memories with registered
//   reads, so one item is in work at a time
// reset: stack empty, error mask clear, no expression open, clear_each_run 1,
//   empty-result value 0; no clearing pass, the block is ready after reset
// a stalled receiver holds the result in the output register; the block keeps
//   taking items until a second result is ready, which then waits
`default_nettype none

module rpn_stack_evaluator_core #(
  parameter int unsigned STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF,
  parameter int unsigned VALUE_WIDTH = rpn_pkg::VALUE_WIDTH_DEF,
  parameter int unsigned VAR_COUNT   = rpn_pkg::VAR_COUNT_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  rpn_stream_if.sink    in_i,
  rpn_stream_if.source  out_o,
  rpn_stream_if.sink    cfg_i
);
  import rpn_pkg::*;

  // command and status between sequencer and datapath
  cmd_t      cmd;
  status_t   status;
  logic      in_ready;
  logic      out_valid;
  out_item_t out_item;
  logic      cfg_we;

  // configuration is always taken
  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid && cfg_i.ready;

  assign in_i.ready    = in_ready;
  assign out_o.valid   = out_valid;
  assign out_o.payload = out_item;

  // sequencer: one entry at a time through exec, wait, pop, take and emit
  rpn_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // stack memory, variable table, multiply/divide unit and output register
  rpn_datapath #(
    .STACK_DEPTH (STACK_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH),
    .VAR_COUNT   (VAR_COUNT)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_i.payload),
    .cfg_we_i    (cfg_we),
    .cfg_item_i  (cfg_i.payload),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_valid),
    .out_item_o  (out_item),
    .cmd_i       (cmd),
    .status_o    (status)
  );

  // a result is loaded only into a free output register
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> (!out_o.valid || out_o.ready))
    else $error("result loaded over a pending result");

  // a loaded result shows up on the output next cycle
  a_emit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |=> out_o.valid)
    else $error("loaded result not presented");

  // only one item in work: no accept right after an accept
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("second item accepted while one is in work");

  // the multiply/divide start never shares a cycle with a stack write
  a_md_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.md_start |-> (!cmd.wb && !cmd.push && !cmd.load))
    else $error("multiply/divide start collides with a stack update");

endmodule

`default_nettype wire

// File: test/rpn_stack_evaluator_core_tb.sv
`timescale 1ns / 100ps

module rpn_stack_evaluator_core_tb;
  import rpn_pkg::*;

  // timing and run length
  localparam int unsigned IDLE_PCT     = 23;
  localparam int unsigned SETTLE_CYC   = 2 * (VALUE_WIDTH_DEF + 6);
  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned N_PHASES     = 8;
  localparam int unsigned PHASE_ITEMS  = 240;
  localparam int unsigned CALM_FIRST   = 700;
  localparam int unsigned CALM_LAST    = 1000;

  // codes the package leaves unnamed
  localparam logic [ACT_W-1:0]     ACT_UNUSED_LO  = 4'd9;
  localparam logic [ACT_W-1:0]     ACT_UNUSED_HI  = 4'd15;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 4'd15;

  typedef logic signed [FIELD_W-1:0] word_t;

  localparam word_t WORD_MIN = 32'sh8000_0000;
  localparam word_t WORD_MAX = 32'sh7fff_ffff;

  localparam action_e ARITH_OPS [5] = '{ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV, ACT_MOD};

  // what the feeder hands over: an entry, a register write, or a pause until drained
  typedef enum logic [1:0] {
    ENT_ITEM,
    ENT_CFG,
    ENT_DRAIN
  } entry_kind_e;

  typedef struct {
    entry_kind_e kind;
    in_item_t    item;
    cfg_item_t   cfg;
  } entry_t;

  logic clk_i;
  logic rst_ni;

  rpn_stream_if #(.T(in_item_t))  in_if ();
  rpn_stream_if #(.T(out_item_t)) out_if ();
  rpn_stream_if #(.T(cfg_item_t)) cfg_if ();

  rpn_stack_evaluator_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // pending entries and expected results
  entry_t    entry_q [$];
  out_item_t rpn_results_q [$];

  // evaluator mirror: stack, sticky errors, variables, registers
  word_t            stk [STACK_DEPTH_DEF];
  int unsigned      stk_cnt = 0;
  logic [ERR_W-1:0] err_mask = '0;
  logic             expr_open = 1'b0;
  word_t            var_tab [VAR_COUNT_DEF];
  logic             clr_each = 1'b1;
  word_t            miss_val = '0;

  // stimulus builder bookkeeping
  logic [SLOT_CNT-1:0] slot_written = '0;
  logic                gen_open = 1'b0;
  int unsigned         gen_count = 0;

  int unsigned mismatches = 0;
  int unsigned items_taken = 0;
  int unsigned settle_cnt = 0;
  int unsigned cycles = 0;
  logic        in_taken = 1'b0;
  logic        cfg_taken = 1'b0;
  logic        calm;

  // a stretch in the middle of the run where neither side idles
  assign calm = (items_taken >= CALM_FIRST) && (items_taken < CALM_LAST);

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // evaluator mirror
  // ---------------------------------------------------------------------------

  // push with overflow drop
  function automatic void push_word(word_t v);
    if (stk_cnt >= STACK_DEPTH_DEF) begin
      err_mask |= ERR_OVF;
    end else begin
      stk[stk_cnt] = v;
      stk_cnt++;
    end
  endfunction

  // fold the two top values into one; too few values leaves the stack alone
  function automatic void combine_top(logic [ACT_W-1:0] op);
    word_t  lhs;
    word_t  rhs;
    word_t  res;
    longint wide_l;
    longint wide_r;
    longint wide_q;
    if (stk_cnt < 2) begin
      err_mask |= ERR_UNF;
      return;
    end
    rhs = stk[stk_cnt-1];
    lhs = stk[stk_cnt-2];
    wide_l = lhs;
    wide_r = rhs;
    case (op)
      ACT_ADD: res = lhs + rhs;
      ACT_SUB: res = lhs - rhs;
      ACT_MUL: res = lhs * rhs;
      default: begin
        // divide by zero gives zero; most negative over minus one wraps in the slice
        if (rhs == 0) begin
          err_mask |= ERR_DZ;
          res = '0;
        end else begin
          wide_q = (op == ACT_DIV) ? (wide_l / wide_r) : (wide_l % wide_r);
          res = wide_q[FIELD_W-1:0];
        end
      end
    endcase
    stk_cnt--;
    stk[stk_cnt-1] = res;
  endfunction

  // one accepted entry; queues a result when the expression ends
  function automatic void rpn_eval_entry(in_item_t it);
    int unsigned slot;
    out_item_t   res;
    slot = it.var_index % VAR_COUNT_DEF;
    // variable write stays outside the expression
    if (it.action == ACT_WRITE_VAR) begin
      var_tab[slot] = it.operand_value;
      return;
    end
    // first entry of an expression may wipe stack and errors
    if (!expr_open) begin
      if (clr_each) begin
        stk_cnt = 0;
        err_mask = '0;
      end
      expr_open = 1'b1;
    end
    if (it.action == ACT_ABORT) begin
      res.result_value = miss_val;
      res.was_missing = 1'b1;
    end else begin
      case (it.action)
        ACT_PUSH_CONST: push_word(it.operand_value);
        ACT_PUSH_VAR:   push_word(var_tab[slot]);
        ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV, ACT_MOD: combine_top(it.action);
        default: ;
      endcase
      if (!it.last) return;
      // final pop, empty stack gives the missing value
      if (stk_cnt == 0) begin
        err_mask |= ERR_UNF;
        res.result_value = miss_val;
        res.was_missing = 1'b1;
      end else begin
        stk_cnt--;
        res.result_value = stk[stk_cnt];
        res.was_missing = 1'b0;
      end
    end
    res.error_flags = err_mask;
    expr_open = 1'b0;
    rpn_results_q.push_back(res);
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus builders
  // ---------------------------------------------------------------------------

  // extremes, small values for divisors, and full random words
  function automatic word_t rand_word();
    case ($urandom_range(9))
      0:       return WORD_MIN;
      1:       return WORD_MAX;
      2:       return '0;
      3:       return -1;
      4, 5:    return word_t'(int'($urandom_range(19)) - 10);
      default: return $urandom;
    endcase
  endfunction

  // only slots that were written may be read
  function automatic logic [VIDX_W-1:0] written_slot();
    logic [VIDX_W-1:0] s;
    do begin
      s = VIDX_W'($urandom_range(SLOT_CNT-1));
    end while (!slot_written[s]);
    return s;
  endfunction

  function automatic void add_item(logic [ACT_W-1:0] act, word_t val,
                                   logic [VIDX_W-1:0] idx, logic last);
    entry_t e;
    e.kind = ENT_ITEM;
    e.item.action = act;
    e.item.operand_value = val;
    e.item.var_index = idx;
    e.item.last = last;
    e.cfg = '0;
    entry_q.push_back(e);
    gen_count++;
    if (act == ACT_WRITE_VAR) slot_written[idx] = 1'b1;
    else gen_open = !(last || act == ACT_ABORT);
  endfunction

  // push a constant or a written variable
  function automatic void add_operand(logic last);
    if ($urandom_range(99) < 30) add_item(ACT_PUSH_VAR, rand_word(), written_slot(), last);
    else add_item(ACT_PUSH_CONST, rand_word(), VIDX_W'($urandom_range(SLOT_CNT-1)), last);
  endfunction

  function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [FIELD_W-1:0] data);
    entry_t e;
    e.kind = ENT_CFG;
    e.item = '0;
    e.cfg.index = idx;
    e.cfg.data = data;
    entry_q.push_back(e);
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus, reset and end of run
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    entry_t      pause;
    int unsigned dir_count;
    int unsigned pick;
    int unsigned depth;
    logic [ACT_W-1:0]  act;
    logic [VIDX_W-1:0] idx;
    word_t       miss;

    // every input known from time zero
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.payload = '0;
    cfg_if.valid = 1'b0;
    cfg_if.payload = '0;
    out_if.ready = 1'b0;

    pause.kind = ENT_DRAIN;
    pause.item = '0;
    pause.cfg = '0;

    // directed: variable writes (last ignored), extremes, every operation
    add_item(ACT_WRITE_VAR, WORD_MAX, 4'd0, 1'b1);
    add_item(ACT_WRITE_VAR, WORD_MIN, 4'd15, 1'b0);
    // min + max
    add_item(ACT_PUSH_CONST, WORD_MIN, 4'd15, 1'b0);
    add_item(ACT_PUSH_VAR, '0, 4'd0, 1'b0);
    add_item(ACT_ADD, '0, 4'd0, 1'b1);
    // most negative over minus one
    add_item(ACT_PUSH_VAR, '0, 4'd15, 1'b0);
    add_item(ACT_PUSH_CONST, -1, 4'd0, 1'b0);
    add_item(ACT_DIV, '0, 4'd0, 1'b1);
    // most negative modulo minus one
    add_item(ACT_PUSH_CONST, WORD_MIN, 4'd0, 1'b0);
    add_item(ACT_PUSH_CONST, -1, 4'd0, 1'b0);
    add_item(ACT_MOD, '0, 4'd0, 1'b1);
    // divide by zero
    add_item(ACT_PUSH_CONST, -7, 4'd0, 1'b0);
    add_item(ACT_PUSH_CONST, '0, 4'd0, 1'b0);
    add_item(ACT_DIV, '0, 4'd0, 1'b1);
    // product wraps to zero
    add_item(ACT_PUSH_CONST, 32'sh0001_0000, 4'd0, 1'b0);
    add_item(ACT_PUSH_CONST, 32'sh0001_0000, 4'd0, 1'b0);
    add_item(ACT_MUL, '0, 4'd0, 1'b1);
    // sub on a single value underflows, value still popped
    add_item(ACT_PUSH_CONST, 32'sd5, 4'd0, 1'b0);
    add_item(ACT_SUB, '0, 4'd0, 1'b1);
    // empty stack at the end
    add_item(ACT_ADD, '0, 4'd0, 1'b1);
    // abort leaves the stack alone
    add_item(ACT_PUSH_CONST, 32'sd3, 4'd0, 1'b0);
    add_item(ACT_ABORT, '0, 4'd0, 1'b0);
    // unused codes change nothing, last still ends
    add_item(ACT_PUSH_CONST, 32'sd4, 4'd0, 1'b0);
    add_item(ACT_UNUSED_LO, '1, 4'd0, 1'b0);
    add_item(ACT_UNUSED_HI, '0, 4'd0, 1'b1);
    dir_count = gen_count;

    // random phases, each under its own register setting
    for (int p = 0; p < N_PHASES; p++) begin
      if (gen_open) add_operand(1'b1);
      entry_q.push_back(pause);
      case (p)
        0:       miss = WORD_MIN;
        1:       miss = WORD_MAX;
        2:       miss = -1;
        3:       miss = '0;
        default: miss = $urandom;
      endcase
      // upper data bits of the clear flag are don't-care
      add_cfg(CFG_CLEAR_EACH_RUN, {31'($urandom_range(32'h7fff_ffff)), 1'(p % 2)});
      add_cfg(CFG_DEFAULT_RES, miss);
      if (p == 3) add_cfg(CFG_UNUSED_IDX, $urandom);

      while (gen_count < dir_count + (p + 1) * PHASE_ITEMS) begin
        pick = $urandom_range(99);
        if (pick < 6) begin
          add_item(ACT_WRITE_VAR, rand_word(), VIDX_W'($urandom_range(SLOT_CNT-1)),
                   1'($urandom_range(1)));
        end else if (pick < 12) begin
          // noise: any code, any flags
          act = ACT_W'($urandom_range(15));
          idx = (act == ACT_PUSH_VAR) ? written_slot() : VIDX_W'($urandom_range(SLOT_CNT-1));
          add_item(act, rand_word(), idx, $urandom_range(99) < 30);
        end else if (pick < 16) begin
          repeat ($urandom_range(3)) add_operand(1'b0);
          add_item(ACT_ABORT, rand_word(), VIDX_W'($urandom_range(SLOT_CNT-1)),
                   1'($urandom_range(1)));
        end else if (pick < 21) begin
          // deep expression: pushes from one short of the top to past it, then fold down
          depth = $urandom_range(STACK_DEPTH_DEF + 4, STACK_DEPTH_DEF - 1);
          repeat (depth) add_operand(1'b0);
          for (int k = 1; k < depth; k++)
            add_item(ARITH_OPS[$urandom_range(4)], rand_word(),
                     VIDX_W'($urandom_range(SLOT_CNT-1)), k == depth - 1);
        end else begin
          // well-formed chain: a b op c op ...
          depth = $urandom_range(5, 1);
          add_operand(depth == 1);
          for (int k = 1; k < depth; k++) begin
            add_operand(1'b0);
            add_item(ARITH_OPS[$urandom_range(4)], rand_word(),
                     VIDX_W'($urandom_range(SLOT_CNT-1)), k == depth - 1);
          end
        end
      end
    end
    if (gen_open) add_operand(1'b1);

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    wait (entry_q.size() == 0);
    wait (rpn_results_q.size() == 0);
    repeat (SETTLE_CYC) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // driver: handshakes seen at the rising edge, new values at the falling edge
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : take_entries
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        rpn_eval_entry(in_if.payload);
        void'(entry_q.pop_front());
        in_taken = 1'b1;
        items_taken++;
      end
      if (cfg_if.valid && cfg_if.ready) begin
        if (cfg_if.payload.index == CFG_CLEAR_EACH_RUN) clr_each = cfg_if.payload.data[0];
        else if (cfg_if.payload.index == CFG_DEFAULT_RES) miss_val = cfg_if.payload.data;
        void'(entry_q.pop_front());
        cfg_taken = 1'b1;
      end
    end
  end

  always @(negedge clk_i) begin : feed_entries
    logic      nxt_in_v;
    logic      nxt_cfg_v;
    in_item_t  nxt_item;
    cfg_item_t nxt_cfg;
    // an offered item stays up until taken
    nxt_in_v = in_if.valid && !in_taken;
    nxt_cfg_v = cfg_if.valid && !cfg_taken;
    nxt_item = in_if.payload;
    nxt_cfg = cfg_if.payload;
    in_taken = 1'b0;
    cfg_taken = 1'b0;
    if (rst_ni && !nxt_in_v && !nxt_cfg_v && entry_q.size() > 0) begin
      case (entry_q[0].kind)
        ENT_ITEM: begin
          if (calm || $urandom_range(99) >= IDLE_PCT) begin
            nxt_in_v = 1'b1;
            nxt_item = entry_q[0].item;
          end
        end
        ENT_CFG: begin
          if (calm || $urandom_range(99) >= IDLE_PCT) begin
            nxt_cfg_v = 1'b1;
            nxt_cfg = entry_q[0].cfg;
          end
        end
        default: begin
          // hold off until every result is back, then let entries with no result finish
          if (rpn_results_q.size() != 0) begin
            settle_cnt = 0;
          end else if (settle_cnt >= SETTLE_CYC) begin
            void'(entry_q.pop_front());
            settle_cnt = 0;
          end else begin
            settle_cnt++;
          end
        end
      endcase
    end
    in_if.valid <= nxt_in_v;
    in_if.payload <= nxt_item;
    cfg_if.valid <= nxt_cfg_v;
    cfg_if.payload <= nxt_cfg;
  end

  // ---------------------------------------------------------------------------
  // monitor: random back-pressure, results checked against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin : pace_results
    out_if.ready <= rst_ni && (calm || $urandom_range(99) >= IDLE_PCT);
  end

  function automatic void flag_mismatch(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%s", msg);
  endfunction

  always @(posedge clk_i) begin : check_results
    out_item_t want;
    out_item_t got;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = out_if.payload;
      if (rpn_results_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected result: value %0d flags %b missing %b",
                                got.result_value, got.error_flags, got.was_missing));
      end else begin
        want = rpn_results_q.pop_front();
        if (got.result_value !== want.result_value || got.error_flags !== want.error_flags ||
            got.was_missing !== want.was_missing)
          flag_mismatch($sformatf(
            "result differs: expected value %0d flags %b missing %b, got value %0d flags %b missing %b",
            want.result_value, want.error_flags, want.was_missing,
            got.result_value, got.error_flags, got.was_missing));
      end
    end
  end

  // hang guard
  always @(posedge clk_i) begin : watchdog
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

endmodule

// File: filelist.f
src/rpn_pkg.sv
src/rpn_stream_if.sv
src/rpn_muldiv.sv
src/rpn_datapath.sv
src/rpn_ctrl.sv
src/rpn_stack_evaluator_core.sv
test/rpn_stack_evaluator_core_tb.sv
